// File: rtl/qea_pkg.sv
package qea_pkg;

	// Operation codes carried by each input item.
	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_ZERO   = 2'd1,
		FUNC_TAKE   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// Register indexes on the configuration port (byte address is 4 times the index).
	localparam logic [1:0] REG_KIND    = 2'd0;
	localparam logic [1:0] REG_TRIGGER = 2'd1;
	localparam logic [1:0] REG_SPEED   = 2'd2;
	localparam logic [1:0] REG_LIMIT   = 2'd3;

	localparam logic [2:0]  KIND_RESET    = 3'd2;
	localparam logic [3:0]  TRIGGER_RESET = 4'd6;
	localparam logic [3:0]  SPEED_RESET   = 4'd3;
	localparam logic [13:0] LIMIT_RESET   = 14'd10000;

	localparam logic [2:0]  KIND_MAX      = 3'd4;
	localparam logic [31:0] DECAY_FAST_MS = 32'd100;
	localparam logic [31:0] DECAY_IDLE_MS = 32'd500;
	localparam logic [31:0] LAST_DETENT_RESET = 32'd500;
	localparam logic [3:0]  COUNT_MAX     = 4'd12;

	localparam logic signed [1:0] DIR_UP   = 2'sb01;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;

	// Direction of a transition, indexed by {previous code, current code}.
	localparam logic signed [1:0] DIR_TABLE [16] = '{
		2'sb00, 2'sb11, 2'sb01, 2'sb00,
		2'sb01, 2'sb00, 2'sb00, 2'sb11,
		2'sb11, 2'sb00, 2'sb00, 2'sb01,
		2'sb00, 2'sb01, 2'sb11, 2'sb00
	};

	// Bit c set: pin code c is a detent for this encoder kind.
	localparam logic [3:0] DETENT_MASK [5] = '{4'h8, 4'h1, 4'h9, 4'h6, 4'hF};
	localparam logic [1:0] RES_SHIFT   [5] = '{2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

	typedef struct packed {
		logic [2:0]  encoder_kind;
		logic [3:0]  fast_trigger;
		logic [3:0]  fast_speed;
		logic [13:0] position_limit;
	} cfg_t;

	typedef struct packed {
		logic [3:0] detent_count;
		logic [1:0] last_pin_code;
	} stat_t;

endpackage

// File: rtl/qea_regs.sv
module qea_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output qea_pkg::cfg_t    cfg
);

	qea_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_kind   <= qea_pkg::KIND_RESET;
			cfg_q.fast_trigger   <= qea_pkg::TRIGGER_RESET;
			cfg_q.fast_speed     <= qea_pkg::SPEED_RESET;
			cfg_q.position_limit <= qea_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				qea_pkg::REG_KIND:    cfg_q.encoder_kind   <= pwdata[2:0];
				qea_pkg::REG_TRIGGER: cfg_q.fast_trigger   <= pwdata[3:0];
				qea_pkg::REG_SPEED:   cfg_q.fast_speed     <= pwdata[3:0];
				qea_pkg::REG_LIMIT:   cfg_q.position_limit <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			qea_pkg::REG_KIND:    prdata = {29'd0, cfg_q.encoder_kind};
			qea_pkg::REG_TRIGGER: prdata = {28'd0, cfg_q.fast_trigger};
			qea_pkg::REG_SPEED:   prdata = {28'd0, cfg_q.fast_speed};
			qea_pkg::REG_LIMIT:   prdata = {18'd0, cfg_q.position_limit};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/qea_core.sv
module qea_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [1:0]       func,
	input  logic             pin_a,
	input  logic             pin_b,
	input  logic [31:0]      now_ms,
	input  qea_pkg::cfg_t    cfg,
	output logic [15:0]      res_position,
	output logic [31:0]      res_delta,
	output logic             res_moved,
	output qea_pkg::stat_t   stat
);

	logic [1:0]  last_code_q, last_code_n;
	logic [19:0] fine_q, fine_n;
	logic [15:0] detpos_q, detpos_n;
	logic [15:0] last_rep_q, last_rep_n;
	logic [31:0] sum_q, sum_n;
	logic [3:0]  count_q, count_n;
	logic [31:0] last_decay_q, last_decay_n;
	logic [31:0] prev_detent_q, prev_detent_n;
	logic [31:0] last_detent_q, last_detent_n;

	qea_pkg::func_t     func_c;
	logic [1:0]         code_c;
	logic [2:0]         kind_c;
	logic [31:0]        elapsed_decay, elapsed_prev;
	logic [3:0]         speed;
	logic [5:0]         step;
	logic signed [1:0]  dir;
	logic [15:0]        d;
	logic signed [17:0] reach, lim, neg_lim;

	assign func_c = qea_pkg::func_t'(func);
	// The pins are active low; pin_a is bit 0 of the code.
	assign code_c = {~pin_b, ~pin_a};
	assign kind_c = (cfg.encoder_kind > qea_pkg::KIND_MAX) ? qea_pkg::KIND_MAX
		: cfg.encoder_kind;
	assign elapsed_decay = now_ms - last_decay_q;
	assign elapsed_prev  = now_ms - prev_detent_q;
	assign lim     = {4'd0, cfg.position_limit};
	assign neg_lim = -lim;
	assign stat.detent_count  = count_q;
	assign stat.last_pin_code = last_code_q;

	always_comb begin
		last_code_n   = last_code_q;
		fine_n        = fine_q;
		detpos_n      = detpos_q;
		last_rep_n    = last_rep_q;
		sum_n         = sum_q;
		count_n       = count_q;
		last_decay_n  = last_decay_q;
		prev_detent_n = prev_detent_q;
		last_detent_n = last_detent_q;
		res_moved     = 1'b0;
		res_delta     = sum_q;
		speed         = 4'd1;
		step          = 6'd0;
		dir           = 2'sb00;
		d             = 16'd0;
		reach         = 18'sd0;
		case (func_c)
			qea_pkg::FUNC_SAMPLE: begin
				// Acceleration decays one detent per 100 ms, or drops to zero when idle.
				if (elapsed_decay > qea_pkg::DECAY_FAST_MS && count_q > 4'd1) begin
					last_decay_n = now_ms;
					count_n      = count_q - 4'd1;
				end else if (elapsed_prev > qea_pkg::DECAY_IDLE_MS) begin
					last_decay_n = now_ms;
					count_n      = 4'd0;
				end
				if (code_c != last_code_q) begin
					speed = (count_n > cfg.fast_trigger) ? cfg.fast_speed : 4'd1;
					step  = {2'd0, speed} << qea_pkg::RES_SHIFT[kind_c];
					dir   = qea_pkg::DIR_TABLE[{last_code_q, code_c}];
					if (dir == qea_pkg::DIR_UP) begin
						fine_n = fine_q + {14'd0, step};
					end else if (dir == qea_pkg::DIR_DOWN) begin
						fine_n = fine_q - {14'd0, step};
					end
					if (qea_pkg::DETENT_MASK[kind_c][code_c]) begin
						prev_detent_n = last_detent_q;
						last_detent_n = now_ms;
						detpos_n      = fine_n[17:2];
						count_n       = (count_n >= qea_pkg::COUNT_MAX) ? qea_pkg::COUNT_MAX
							: count_n + 4'd1;
					end
					last_code_n = code_c;
				end
				if (detpos_n != last_rep_q) begin
					res_moved  = 1'b1;
					d          = detpos_n - last_rep_q;
					sum_n      = sum_q + {{16{d[15]}}, d};
					reach      = $signed({{2{detpos_n[15]}}, detpos_n})
						+ $signed({d[15], d, 1'b0});
					// The guard wraps the position to zero once it would pass the limit.
					if ((!d[15] && reach > lim) || (d[15] && reach < neg_lim)) begin
						fine_n   = {18'd0, fine_n[1:0]};
						detpos_n = 16'd0;
					end
					last_rep_n = detpos_n;
				end
				res_delta = sum_n;
			end
			qea_pkg::FUNC_ZERO: begin
				fine_n   = {18'd0, fine_q[1:0]};
				detpos_n = 16'd0;
			end
			qea_pkg::FUNC_TAKE: begin
				sum_n = 32'd0;
			end
			default: ;
		endcase
		res_position = detpos_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q   <= 2'd0;
			fine_q        <= 20'd0;
			detpos_q      <= 16'd0;
			last_rep_q    <= 16'd0;
			sum_q         <= 32'd0;
			count_q       <= 4'd0;
			last_decay_q  <= 32'd0;
			prev_detent_q <= 32'd0;
			last_detent_q <= qea_pkg::LAST_DETENT_RESET;
		end else if (en) begin
			last_code_q   <= last_code_n;
			fine_q        <= fine_n;
			detpos_q      <= detpos_n;
			last_rep_q    <= last_rep_n;
			sum_q         <= sum_n;
			count_q       <= count_n;
			last_decay_q  <= last_decay_n;
			prev_detent_q <= prev_detent_n;
			last_detent_q <= last_detent_n;
		end
	end

endmodule

// File: rtl/quadrature_encoder_with_acceleration.sv
// Quadrature encoder decoder with acceleration. Every input transfer carries one
// operation (sample the pins, zero the position, or take and clear the accumulated
// delta) and yields exactly one result transfer. The block takes one item per clock
// cycle unless the input stalls. An accepted item is held in the input register; when
// it advances, a single pass through the decoder updates its state and loads the
// result into the output register, from which the result transfer is made. A stalled
// result holds the output register, and once the input register is also full the input
// stalls. Configuration registers sit at byte addresses 0, 4, 8 and 12 and should be
// written only while no items are in flight.
module quadrature_encoder_with_acceleration (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic               pin_a,
	input  logic               pin_b,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] position,
	output logic signed [31:0] delta,
	output logic               moved
);

	qea_pkg::cfg_t  cfg;
	qea_pkg::stat_t stat;

	logic        s1_valid_q;
	logic [1:0]  func_s1;
	logic        pin_a_s1, pin_b_s1;
	logic [31:0] now_s1;
	logic        out_valid_q;
	logic [15:0] res_position;
	logic [31:0] res_delta;
	logic        res_moved;
	logic        advance, load;

	// An item leaves the input register whenever the output register is free or drains.
	assign advance  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !advance;
	assign load     = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	qea_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qea_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.func         (func_s1),
		.pin_a        (pin_a_s1),
		.pin_b        (pin_b_s1),
		.now_ms       (now_s1),
		.cfg          (cfg),
		.res_position (res_position),
		.res_delta    (res_delta),
		.res_moved    (res_moved),
		.stat         (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			func_s1  <= func;
			pin_a_s1 <= pin_a;
			pin_b_s1 <= pin_b;
			now_s1   <= now_ms;
		end
		if (advance) begin
			position <= res_position;
			delta    <= res_delta;
			moved    <= res_moved;
		end
	end

`ifndef SYNTH
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after an item advanced");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with an empty input register");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		stat.detent_count <= qea_pkg::COUNT_MAX)
		else $error("detent count passed its saturation value");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(stat))
		else $error("decoder state changed without an item");
`endif

endmodule
